### rtl/opw_pkg.sv
package opw_pkg;
   localparam int MAX_RADIUS = 5;
   localparam int BIN_COUNT = 256;
   localparam int PIX_W = 8;
   localparam int CNT_W = 7;
   localparam int SUM_W = 15;
   localparam int CSR_RADIUS = 0;
   localparam int CSR_LEVELS = 1;
   localparam logic [7:0] RADIUS_RESET = 8'd1;
   localparam logic [7:0] LEVELS_RESET = 8'd30;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } bin_type;
endpackage

### rtl/opw_ram.sv
module opw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/opw_div.sv
// restoring divider: 15-bit sum / 7-bit count, one quotient bit per cycle
// done and quotient are registered and appear in the cycle after the last step
module opw_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [14:0] dividend,
   input  logic [6:0]  divisor,
   output logic        done,
   output logic [7:0]  quotient
);
   logic [15:0] quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic [6:0]  dvs_ff;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff;
   logic [8:0]  trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial = {rem_ff, quo_ff[15]} - {2'b00, dvs_ff};
      if (go) begin
         quo_in = {1'b0, dividend} + {10'd0, divisor[6:1]};
         rem_in = '0;
         step_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[8]) begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[6:0], quo_ff[15]};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= busy_ff && (step_ff == 5'd15);
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (go) begin
         dvs_ff <= divisor;
      end
   end

   assign done = done_ff;
   assign quotient = (quo_ff[15:8] != 8'd0) ? 8'hFF : quo_ff[7:0];
endmodule

### rtl/oil_paint_window_mode_color.sv
// channel | dir | ports                                        | handshake
// req     | in  | req_red/green/blue/alpha/intensity           | start & !busy
// rsp     | out | rsp_out_red/green/blue/alpha, rsp_empty_window | rsp_valid, 1 cycle
// csr     | in  | csr_wr_en, csr_index, csr_wdata              | csr_wr_en
// A non-final pixel is taken without raising busy: a pipelined read-modify-write of one bin
// through the registered memory read, with a bypass for back-to-back hits.
// The last pixel starts a scan of all BIN_COUNT bins, one a cycle once the
// pending update is written, clearing each bin behind the scan, then, unless
// the window is empty, three divides. After reset a sweep clears all bins;
// busy stays high. Results cannot be stalled; rsp_valid is high for one cycle.
module oil_paint_window_mode_color #(
   parameter int BIN_COUNT = opw_pkg::BIN_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_alpha,
   input  logic [7:0] req_intensity,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha,
   output logic       rsp_empty_window,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   localparam int BW = $clog2(BIN_COUNT);
   localparam int DW = $bits(opw_pkg::bin_type);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_DR, S_DG, S_DB, S_OUT
   } state_type;

   state_type state_ff;
   logic [2:0] radius_ff;
   logic [7:0] levels_ff;
   logic [6:0] pix_ff;
   logic [7:0] calpha_ff;
   logic [BW:0] addr_ff;
   // pipelined update stage
   logic        upd_ff;
   logic [BW-1:0] ubin_ff;
   logic [7:0]  ur_ff, ug_ff, ub_ff;
   // read-after-write bypass
   logic        fwd_hit_ff;
   opw_pkg::bin_type fwd_data_ff;
   // scan stage
   logic        sv_ff;
   logic [BW-1:0] sidx_ff;
   opw_pkg::bin_type best_ff;
   logic [7:0]  mr_ff, mg_ff, mb_ff, out_alpha_ff;
   logic        empty_ff, valid_ff;

   logic        wr_en;
   logic [BW-1:0] wr_addr, rd_addr;
   opw_pkg::bin_type wr_data, rd_data, cur;
   logic        accept;
   logic [2:0]  r_eff;
   logic [6:0]  side, size, centre;
   logic [15:0] prod;
   logic [7:0]  bin_full;
   logic [BW-1:0] bin;
   logic        last;
   logic        addr_end, scan_end, pick_empty;
   logic        div_go, div_done;
   logic [14:0] div_num;
   logic [7:0]  div_q;
   opw_pkg::bin_type upd_base;

   opw_ram #(.WIDTH(DW), .DEPTH(BIN_COUNT)) u_bins (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   opw_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(div_num),
      .divisor(best_ff.count), .done(div_done), .quotient(div_q)
   );

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign r_eff = (radius_ff > 3'(opw_pkg::MAX_RADIUS)) ? 3'(opw_pkg::MAX_RADIUS)
                                                       : radius_ff;
   assign side = {3'd0, r_eff, 1'b1};
   assign size = 7'(side * side);
   assign centre = 7'(r_eff * side) + {4'd0, r_eff};
   assign prod = req_intensity * levels_ff;
   // floor(p/255) for p <= 65025: q = (p + (p>>8) + 1) >> 8
   assign bin_full = 8'((17'(prod) + 17'(prod[15:8]) + 17'd1) >> 8);
   assign bin = (bin_full > 8'(BIN_COUNT - 1)) ? BW'(BIN_COUNT - 1) : BW'(bin_full);
   assign last = !(pix_ff + 7'd1 < size);

   // scan position past the last bin; decision cycle once the pipe is empty
   assign addr_end = (addr_ff == (BW+1)'(BIN_COUNT));
   assign scan_end = (state_ff == S_SCAN) && !sv_ff && addr_end && !upd_ff;
   assign pick_empty = (calpha_ff == 8'd0) || (best_ff.count == '0);

   // forwarding: previous update not yet visible in the read data
   assign upd_base = fwd_hit_ff ? fwd_data_ff : rd_data;
   always_comb begin
      cur = upd_base;
      cur.count = upd_base.count + 7'd1;
      cur.red = upd_base.red + 15'(ur_ff);
      cur.green = upd_base.green + 15'(ug_ff);
      cur.blue = upd_base.blue + 15'(ub_ff);
   end

   always_comb begin
      rd_addr = accept ? bin : addr_ff[BW-1:0];
      wr_en = 1'b0;
      wr_addr = ubin_ff;
      wr_data = cur;
      if (upd_ff) begin
         wr_en = 1'b1;
      end else if (state_ff == S_CLEAR || state_ff == S_SCAN) begin
         wr_en = (state_ff == S_CLEAR) || sv_ff;
         wr_addr = (state_ff == S_CLEAR) ? addr_ff[BW-1:0] : sidx_ff;
         wr_data = '0;
      end
   end

   // operand for the divide started in this cycle
   always_comb begin
      unique case (state_ff)
         S_DR:    div_num = best_ff.green;
         S_DG:    div_num = best_ff.blue;
         default: div_num = best_ff.red;
      endcase
   end
   assign div_go = (scan_end && !pick_empty) ||
                   (div_done && (state_ff == S_DR || state_ff == S_DG));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         radius_ff <= opw_pkg::RADIUS_RESET[2:0];
         levels_ff <= opw_pkg::LEVELS_RESET;
         pix_ff <= '0;
         calpha_ff <= '0;
         addr_ff <= '0;
         upd_ff <= 1'b0;
         sv_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (state_ff == S_OUT);
         if (csr_wr_en) begin
            if (csr_index == 1'(opw_pkg::CSR_RADIUS)) radius_ff <= csr_wdata[2:0];
            else levels_ff <= csr_wdata;
         end
         upd_ff <= accept && req_alpha != 8'd0;
         // hold off the bin reads while an update is pending
         sv_ff <= (state_ff == S_SCAN) && !upd_ff && !addr_end;
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == (BW+1)'(BIN_COUNT - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  if (pix_ff == centre) calpha_ff <= req_alpha;
                  if (last) begin
                     state_ff <= S_SCAN;
                     addr_ff <= '0;
                     pix_ff <= '0;
                     best_ff <= '0;
                     empty_ff <= 1'b0;
                  end else begin
                     pix_ff <= pix_ff + 7'd1;
                  end
               end
            end
            S_SCAN: begin
               if (!upd_ff && !addr_end) addr_ff <= addr_ff + 1'b1;
               if (sv_ff && rd_data.count > best_ff.count) best_ff <= rd_data;
               if (scan_end) begin
                  if (pick_empty) begin
                     mr_ff <= '0; mg_ff <= '0; mb_ff <= '0;
                     empty_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_DR;
                  end
               end
            end
            S_DR: if (div_done) begin mr_ff <= div_q; state_ff <= S_DG; end
            S_DG: if (div_done) begin mg_ff <= div_q; state_ff <= S_DB; end
            S_DB: if (div_done) begin mb_ff <= div_q; state_ff <= S_OUT; end
            S_OUT: begin
               out_alpha_ff <= calpha_ff;
               state_ff <= S_IDLE;
               calpha_ff <= '0;
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
      ubin_ff <= bin;
      ur_ff <= req_red;
      ug_ff <= req_green;
      ub_ff <= req_blue;
      sidx_ff <= addr_ff[BW-1:0];
      fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      fwd_data_ff <= wr_data;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_red = mr_ff;
   assign rsp_out_green = mg_ff;
   assign rsp_out_blue = mb_ff;
   assign rsp_out_alpha = out_alpha_ff;
   assign rsp_empty_window = empty_ff;
endmodule

### rtl/opw_checker.sv
module opw_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_alpha,
   input logic       rsp_empty_window
);
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with result");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_window |-> rsp_out_red == 8'd0)
      else $error("empty window with color");
   a_alpha_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_alpha == 8'd0 |-> rsp_empty_window)
      else $error("transparent centre not empty");
endmodule

bind oil_paint_window_mode_color opw_checker u_opw_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_out_red(rsp_out_red),
   .rsp_out_alpha(rsp_out_alpha), .rsp_empty_window(rsp_empty_window)
);
